FILE: sv/sdsp_pkg.sv
package sdsp_pkg;

    localparam int POSITION_BITS_DEF = 13;

    localparam int LOOP_START      = 11;
    localparam int MIN_SECTION_LEN = 12;
    localparam int CRC_LAST_OFFSET = 3;
    localparam int HEADER_LAST_POS = 9;

    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_SERVICE   = 3'd1;
    localparam logic [2:0] KIND_DESC_HDR  = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
    localparam logic [2:0] KIND_CRC       = 3'd4;
    localparam logic [2:0] KIND_MALFORMED = 3'd5;

    typedef enum logic [3:0] {
        PH_WAIT,
        PH_HDR,
        PH_RSV,
        PH_AREA,
        PH_SVC,
        PH_DLEN,
        PH_DPAY,
        PH_CRC,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       first_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] primary_id;
        logic [15:0] secondary_value;
        logic [7:0]  tbl_id;
        logic [4:0]  version;
        logic [7:0]  sect_num;
        logic [7:0]  last_sect_num;
        logic [2:0]  flag_bits;
        logic [2:0]  run_state;
        logic [11:0] sect_len;
        logic [31:0] crc_value;
        logic [7:0]  data_byte;
    } rec_t;

endpackage

FILE: sv/sdsp_in_stage.sv
module sdsp_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sdsp_pkg::in_t s_data,
    output logic          in_valid,
    input  logic          take,
    output sdsp_pkg::in_t in_data
);

    logic          valid_reg;
    sdsp_pkg::in_t data_reg;

    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    // held byte must survive until the parser takes it
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !take |=> valid_reg && $stable(data_reg))
        else $error("input stage lost a held byte");

endmodule

FILE: sv/sdsp_parser.sv
module sdsp_parser #(
    parameter int POSITION_BITS = sdsp_pkg::POSITION_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  sdsp_pkg::in_t  in_data,
    input  logic           q_full,
    output logic           take,
    output logic           rec_valid,
    output sdsp_pkg::rec_t rec
);

    localparam int POS_W = POSITION_BITS + 1;
    localparam int SUM_W = POSITION_BITS + 2;

    localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TSID_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TSID_LO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SEC_NUM  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LAST_NUM = POS_W'(7);
    localparam logic [POS_W-1:0] POS_ONID_HI  = POS_W'(8);

    sdsp_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [7:0]  table_id_reg, table_id_next;
    logic        syntax_reg, syntax_next;
    logic [11:0] sec_len_reg, sec_len_next;
    logic [15:0] tsid_reg, tsid_next;
    logic [4:0]  version_reg, version_next;
    logic        cur_next_reg, cur_next_next;
    logic [7:0]  sec_num_reg, sec_num_next;
    logic [7:0]  last_num_reg, last_num_next;
    logic [7:0]  onid_hi_reg, onid_hi_next;
    logic [15:0] sid_reg, sid_next;
    logic [1:0]  flags_reg, flags_next;
    logic [7:0]  b3_reg, b3_next;
    logic [7:0]  tag_reg, tag_next;
    logic [POS_W-1:0] crc_start_reg, crc_start_next;
    logic [POS_W-1:0] loop_end_reg, loop_end_next;
    logic [POS_W-1:0] desc_end_reg, desc_end_next;
    logic [31:0] crc_reg, crc_next;

    logic [7:0]       b;
    logic [11:0]      len_full;
    logic [11:0]      svc_len;
    logic [POS_W-1:0] svc_k;
    logic [SUM_W-1:0] pos_inc;
    logic [SUM_W-1:0] svc_end;
    logic [SUM_W-1:0] desc_end;
    logic [31:0]      crc_shifted;

    assign take        = in_valid && !q_full;
    assign b           = in_data.section_byte;
    assign len_full    = {sec_len_reg[11:8], b};
    assign svc_len     = {b3_reg[3:0], b};
    assign svc_k       = pos_reg - desc_end_reg;
    assign pos_inc     = SUM_W'(pos_reg) + SUM_W'(1);
    assign svc_end     = pos_inc + SUM_W'(svc_len);
    assign desc_end    = pos_inc + SUM_W'(b);
    assign crc_shifted = {crc_reg[23:0], b};

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        table_id_next  = table_id_reg;
        syntax_next    = syntax_reg;
        sec_len_next   = sec_len_reg;
        tsid_next      = tsid_reg;
        version_next   = version_reg;
        cur_next_next  = cur_next_reg;
        sec_num_next   = sec_num_reg;
        last_num_next  = last_num_reg;
        onid_hi_next   = onid_hi_reg;
        sid_next       = sid_reg;
        flags_next     = flags_reg;
        b3_next        = b3_reg;
        tag_next       = tag_reg;
        crc_start_next = crc_start_reg;
        loop_end_next  = loop_end_reg;
        desc_end_next  = desc_end_reg;
        crc_next       = crc_reg;
        rec_valid      = 1'b0;
        rec            = '0;

        if (take) begin
            if (in_data.first_byte) begin
                table_id_next = b;
                pos_next      = POS_W'(1);
                phase_next    = sdsp_pkg::PH_HDR;
            end else if (phase_reg != sdsp_pkg::PH_WAIT && phase_reg != sdsp_pkg::PH_DONE) begin
                if (pos_reg[POS_W-1]) begin
                    phase_next = sdsp_pkg::PH_DONE;
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                    case (phase_reg)
                        sdsp_pkg::PH_HDR: begin
                            case (pos_reg)
                                POS_LEN_HI: begin
                                    syntax_next  = b[7];
                                    sec_len_next = {b[3:0], 8'h00};
                                end
                                POS_LEN_LO: begin
                                    sec_len_next = len_full;
                                    if (len_full >= 12'(sdsp_pkg::MIN_SECTION_LEN)) begin
                                        crc_start_next = POS_W'(len_full) - POS_W'(1);
                                    end else begin
                                        crc_start_next = '0;
                                    end
                                end
                                POS_TSID_HI:  tsid_next = {b, 8'h00};
                                POS_TSID_LO:  tsid_next = {tsid_reg[15:8], b};
                                POS_VERSION: begin
                                    version_next  = b[5:1];
                                    cur_next_next = b[0];
                                end
                                POS_SEC_NUM:  sec_num_next  = b;
                                POS_LAST_NUM: last_num_next = b;
                                POS_ONID_HI:  onid_hi_next  = b;
                                default: begin
                                    rec_valid           = 1'b1;
                                    rec.record_kind     = sdsp_pkg::KIND_HEADER;
                                    rec.primary_id      = tsid_reg;
                                    rec.secondary_value = {onid_hi_reg, b};
                                    rec.tbl_id          = table_id_reg;
                                    rec.version         = version_reg;
                                    rec.sect_num        = sec_num_reg;
                                    rec.last_sect_num   = last_num_reg;
                                    rec.flag_bits       = {1'b0, syntax_reg, cur_next_reg};
                                    rec.sect_len        = sec_len_reg;
                                    phase_next          = sdsp_pkg::PH_RSV;
                                end
                            endcase
                        end
                        sdsp_pkg::PH_RSV: begin
                            if (sec_len_reg < 12'(sdsp_pkg::MIN_SECTION_LEN)) begin
                                rec_valid       = 1'b1;
                                rec.record_kind = sdsp_pkg::KIND_MALFORMED;
                                phase_next      = sdsp_pkg::PH_DONE;
                            end else begin
                                loop_end_next = POS_W'(sdsp_pkg::LOOP_START);
                                phase_next    = sdsp_pkg::PH_AREA;
                            end
                        end
                        sdsp_pkg::PH_AREA: begin
                            if (pos_reg >= loop_end_reg) begin
                                if (pos_reg == crc_start_reg) begin
                                    crc_next   = {24'h000000, b};
                                    phase_next = sdsp_pkg::PH_CRC;
                                end else begin
                                    sid_next      = {8'h00, b};
                                    flags_next    = 2'b00;
                                    b3_next       = 8'h00;
                                    desc_end_next = pos_reg;
                                    phase_next    = sdsp_pkg::PH_SVC;
                                end
                            end else if (pos_inc == SUM_W'(loop_end_reg)) begin
                                // lone trailing loop byte
                                phase_next = sdsp_pkg::PH_AREA;
                            end else begin
                                tag_next   = b;
                                phase_next = sdsp_pkg::PH_DLEN;
                            end
                        end
                        sdsp_pkg::PH_SVC: begin
                            if (pos_reg >= crc_start_reg) begin
                                rec_valid       = 1'b1;
                                rec.record_kind = sdsp_pkg::KIND_MALFORMED;
                                phase_next      = sdsp_pkg::PH_DONE;
                            end else if (svc_k == POS_W'(1)) begin
                                sid_next = {sid_reg[7:0], b};
                            end else if (svc_k == POS_W'(2)) begin
                                flags_next = b[1:0];
                            end else if (svc_k == POS_W'(3)) begin
                                b3_next = b;
                            end else if (svc_end > SUM_W'(crc_start_reg)) begin
                                rec_valid       = 1'b1;
                                rec.record_kind = sdsp_pkg::KIND_MALFORMED;
                                phase_next      = sdsp_pkg::PH_DONE;
                            end else begin
                                loop_end_next       = svc_end[POS_W-1:0];
                                rec_valid           = 1'b1;
                                rec.record_kind     = sdsp_pkg::KIND_SERVICE;
                                rec.primary_id      = sid_reg;
                                rec.secondary_value = {4'h0, svc_len};
                                rec.flag_bits       = {b3_reg[4], flags_reg};
                                rec.run_state       = b3_reg[7:5];
                                phase_next          = sdsp_pkg::PH_AREA;
                            end
                        end
                        sdsp_pkg::PH_DLEN: begin
                            if (desc_end > SUM_W'(loop_end_reg)) begin
                                rec_valid       = 1'b1;
                                rec.record_kind = sdsp_pkg::KIND_MALFORMED;
                                phase_next      = sdsp_pkg::PH_DONE;
                            end else begin
                                desc_end_next       = desc_end[POS_W-1:0];
                                rec_valid           = 1'b1;
                                rec.record_kind     = sdsp_pkg::KIND_DESC_HDR;
                                rec.primary_id      = {8'h00, tag_reg};
                                rec.secondary_value = {8'h00, b};
                                phase_next = (b != 8'h00) ? sdsp_pkg::PH_DPAY
                                                          : sdsp_pkg::PH_AREA;
                            end
                        end
                        sdsp_pkg::PH_DPAY: begin
                            rec_valid       = 1'b1;
                            rec.record_kind = sdsp_pkg::KIND_PAYLOAD;
                            rec.data_byte   = b;
                            if (pos_inc >= SUM_W'(desc_end_reg)) begin
                                phase_next = sdsp_pkg::PH_AREA;
                            end
                        end
                        sdsp_pkg::PH_CRC: begin
                            crc_next = crc_shifted;
                            if (pos_reg - crc_start_reg >= POS_W'(sdsp_pkg::CRC_LAST_OFFSET)) begin
                                rec_valid       = 1'b1;
                                rec.record_kind = sdsp_pkg::KIND_CRC;
                                rec.crc_value   = crc_shifted;
                                phase_next      = sdsp_pkg::PH_DONE;
                            end
                        end
                        default: begin
                            phase_next = sdsp_pkg::PH_DONE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sdsp_pkg::PH_WAIT;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        table_id_reg  <= table_id_next;
        syntax_reg    <= syntax_next;
        sec_len_reg   <= sec_len_next;
        tsid_reg      <= tsid_next;
        version_reg   <= version_next;
        cur_next_reg  <= cur_next_next;
        sec_num_reg   <= sec_num_next;
        last_num_reg  <= last_num_next;
        onid_hi_reg   <= onid_hi_next;
        sid_reg       <= sid_next;
        flags_reg     <= flags_next;
        b3_reg        <= b3_next;
        tag_reg       <= tag_next;
        crc_start_reg <= crc_start_next;
        loop_end_reg  <= loop_end_next;
        desc_end_reg  <= desc_end_next;
        crc_reg       <= crc_next;
    end

    a_header_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid && rec.record_kind == sdsp_pkg::KIND_HEADER
        |-> pos_reg == POS_W'(sdsp_pkg::HEADER_LAST_POS))
        else $error("header record off its byte");

    a_end_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid && (rec.record_kind == sdsp_pkg::KIND_CRC
                   || rec.record_kind == sdsp_pkg::KIND_MALFORMED)
        |=> phase_reg == sdsp_pkg::PH_DONE)
        else $error("section not closed after final record");

endmodule

FILE: sv/sdsp_out_queue.sv
module sdsp_out_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sdsp_pkg::rec_t push_data,
    output logic           full,
    output logic           m_valid,
    input  logic           m_ready,
    output sdsp_pkg::rec_t m_data
);

    logic [1:0]     count_reg, count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    sdsp_pkg::rec_t entry_reg [2];
    logic           pop;

    assign full    = count_reg == 2'd2;
    assign m_valid = count_reg != 2'd0;
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != 2'd2)
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

FILE: sv/service_description_section_parser.sv
// A byte is registered at the input and parsed; its record is then queued.
// Throughput: one section byte per cycle while the queue is not full, set by
// the parse stage between the input register and a two-entry result queue.
// A byte that causes no record leaves nothing in the queue.
// Reset (aresetn, synchronous, active low) empties both stages and puts the
// parser back to waiting for a first byte.
module service_description_section_parser #(
    parameter int POSITION_BITS = sdsp_pkg::POSITION_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sdsp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sdsp_pkg::rec_t m_data
);

    logic           in_valid;
    sdsp_pkg::in_t  in_data;
    logic           take;
    logic           q_full;
    logic           rec_valid;
    sdsp_pkg::rec_t rec;

    sdsp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .in_valid (in_valid),
        .take     (take),
        .in_data  (in_data)
    );

    sdsp_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_full),
        .take      (take),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    sdsp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_valid),
        .push_data (rec),
        .full      (q_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: tb/service_description_section_parser_tb.sv
module service_description_section_parser_tb;

    localparam int unsigned POS_MAX      = (1 << sdsp_pkg::POSITION_BITS_DEF) - 1;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RANDOM_BYTES = 480;
    localparam int unsigned DRAIN_TAIL   = 8;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    sdsp_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    sdsp_pkg::rec_t m_data;

    service_description_section_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    int unsigned src_idle_pct = 36;
    int unsigned snk_idle_pct = 59;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned records_checked = 0;
    int unsigned malformed_seen = 0;
    int unsigned crc_seen = 0;
    int unsigned sections_sent = 0;
    int unsigned bytes_sent = 0;

    sdsp_pkg::rec_t expected_recs[$];
    bit [7:0] section_bytes[$];

    // parser state
    sdsp_pkg::phase_t sec_phase = sdsp_pkg::PH_WAIT;
    int unsigned byte_pos = 0;
    int unsigned crc_start = 0;
    int unsigned loop_end = 0;
    int unsigned desc_end = 0;
    logic [7:0]  hdr_table_id = '0;
    logic        hdr_syntax = 1'b0;
    logic [11:0] hdr_len = '0;
    logic [15:0] hdr_tsid = '0;
    logic [4:0]  hdr_version = '0;
    logic        hdr_cur_next = 1'b0;
    logic [7:0]  hdr_sec_num = '0;
    logic [7:0]  hdr_last_num = '0;
    logic [7:0]  hdr_onid_hi = '0;
    logic [15:0] svc_id = '0;
    logic [7:0]  svc_flags = '0;
    logic [7:0]  svc_b3 = '0;
    logic [7:0]  desc_tag = '0;
    logic [31:0] crc_acc = '0;

    function automatic sdsp_pkg::rec_t malformed_rec();
        sdsp_pkg::rec_t rec;
        rec = '0;
        rec.record_kind = sdsp_pkg::KIND_MALFORMED;
        sec_phase = sdsp_pkg::PH_DONE;
        return rec;
    endfunction

    function automatic void parse_byte(input sdsp_pkg::in_t item, output bit produces,
                                       output sdsp_pkg::rec_t rec);
        int unsigned pos;
        int unsigned loop_len;
        int unsigned stop;
        logic [7:0] b;
        b = item.section_byte;
        produces = 1'b0;
        rec = '0;
        if (item.first_byte) begin
            hdr_table_id = b;
            hdr_syntax = 1'b0;
            hdr_len = '0;
            hdr_tsid = '0;
            hdr_version = '0;
            hdr_cur_next = 1'b0;
            hdr_sec_num = '0;
            hdr_last_num = '0;
            hdr_onid_hi = '0;
            svc_id = '0;
            svc_flags = '0;
            svc_b3 = '0;
            desc_tag = '0;
            crc_start = 0;
            loop_end = 0;
            desc_end = 0;
            crc_acc = '0;
            byte_pos = 1;
            sec_phase = sdsp_pkg::PH_HDR;
            return;
        end
        if (sec_phase == sdsp_pkg::PH_WAIT || sec_phase == sdsp_pkg::PH_DONE) return;
        pos = byte_pos;
        if (pos > POS_MAX) begin
            sec_phase = sdsp_pkg::PH_DONE;
            return;
        end
        byte_pos = pos + 1;
        case (sec_phase)
            sdsp_pkg::PH_HDR: begin
                case (pos)
                    1: begin
                        hdr_syntax = b[7];
                        hdr_len = {b[3:0], 8'h00};
                    end
                    2: begin
                        hdr_len[7:0] = b;
                        crc_start = (hdr_len >= 12'(sdsp_pkg::MIN_SECTION_LEN))
                                    ? 32'(hdr_len) - 1 : 0;
                    end
                    3: hdr_tsid[15:8] = b;
                    4: hdr_tsid[7:0] = b;
                    5: begin
                        hdr_version = b[5:1];
                        hdr_cur_next = b[0];
                    end
                    6: hdr_sec_num = b;
                    7: hdr_last_num = b;
                    8: hdr_onid_hi = b;
                    default: begin
                        rec.record_kind = sdsp_pkg::KIND_HEADER;
                        rec.primary_id = hdr_tsid;
                        rec.secondary_value = {hdr_onid_hi, b};
                        rec.tbl_id = hdr_table_id;
                        rec.version = hdr_version;
                        rec.sect_num = hdr_sec_num;
                        rec.last_sect_num = hdr_last_num;
                        rec.flag_bits = {1'b0, hdr_syntax, hdr_cur_next};
                        rec.sect_len = hdr_len;
                        produces = 1'b1;
                        sec_phase = sdsp_pkg::PH_RSV;
                    end
                endcase
            end
            sdsp_pkg::PH_RSV: begin
                if (hdr_len < 12'(sdsp_pkg::MIN_SECTION_LEN)) begin
                    rec = malformed_rec();
                    produces = 1'b1;
                end else begin
                    loop_end = sdsp_pkg::LOOP_START;
                    sec_phase = sdsp_pkg::PH_AREA;
                end
            end
            sdsp_pkg::PH_AREA: begin
                if (pos >= loop_end) begin
                    if (pos == crc_start) begin
                        crc_acc = {24'h0, b};
                        sec_phase = sdsp_pkg::PH_CRC;
                    end else begin
                        svc_id = {8'h00, b};
                        svc_flags = '0;
                        svc_b3 = '0;
                        desc_end = pos;
                        sec_phase = sdsp_pkg::PH_SVC;
                    end
                end else if (pos + 1 != loop_end) begin
                    desc_tag = b;
                    sec_phase = sdsp_pkg::PH_DLEN;
                end
            end
            sdsp_pkg::PH_SVC: begin
                if (pos >= crc_start) begin
                    rec = malformed_rec();
                    produces = 1'b1;
                end else begin
                    case (pos - desc_end)
                        1: svc_id = {svc_id[7:0], b};
                        2: svc_flags = b;
                        3: svc_b3 = b;
                        default: begin
                            loop_len = 32'({svc_b3[3:0], b});
                            stop = pos + 1 + loop_len;
                            produces = 1'b1;
                            if (stop > crc_start) begin
                                rec = malformed_rec();
                            end else begin
                                loop_end = stop;
                                rec.record_kind = sdsp_pkg::KIND_SERVICE;
                                rec.primary_id = svc_id;
                                rec.secondary_value = loop_len[15:0];
                                rec.flag_bits = {svc_b3[4], svc_flags[1], svc_flags[0]};
                                rec.run_state = svc_b3[7:5];
                                sec_phase = sdsp_pkg::PH_AREA;
                            end
                        end
                    endcase
                end
            end
            sdsp_pkg::PH_DLEN: begin
                produces = 1'b1;
                if (pos + 1 + 32'(b) > loop_end) begin
                    rec = malformed_rec();
                end else begin
                    desc_end = pos + 1 + 32'(b);
                    rec.record_kind = sdsp_pkg::KIND_DESC_HDR;
                    rec.primary_id = {8'h00, desc_tag};
                    rec.secondary_value = {8'h00, b};
                    sec_phase = (b != 8'h00) ? sdsp_pkg::PH_DPAY : sdsp_pkg::PH_AREA;
                end
            end
            sdsp_pkg::PH_DPAY: begin
                produces = 1'b1;
                rec.record_kind = sdsp_pkg::KIND_PAYLOAD;
                rec.data_byte = b;
                if (pos + 1 >= desc_end) sec_phase = sdsp_pkg::PH_AREA;
            end
            sdsp_pkg::PH_CRC: begin
                crc_acc = {crc_acc[23:0], b};
                if (pos - crc_start >= sdsp_pkg::CRC_LAST_OFFSET) begin
                    produces = 1'b1;
                    rec.record_kind = sdsp_pkg::KIND_CRC;
                    rec.crc_value = crc_acc;
                    sec_phase = sdsp_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want_v, got_v);
            error_count++;
        end
    endfunction

    sdsp_pkg::rec_t predicted;
    sdsp_pkg::rec_t want;
    bit             produces;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_recs.size() == 0) begin
                    $error("record kind %0d with nothing expected", m_data.record_kind);
                    error_count++;
                end else begin
                    want = expected_recs.pop_front();
                    records_checked++;
                    if (want.record_kind == sdsp_pkg::KIND_MALFORMED) malformed_seen++;
                    if (want.record_kind == sdsp_pkg::KIND_CRC) crc_seen++;
                    check_field("record_kind", 32'(want.record_kind),
                                32'(m_data.record_kind));
                    check_field("primary_id", 32'(want.primary_id), 32'(m_data.primary_id));
                    check_field("secondary_value", 32'(want.secondary_value),
                                32'(m_data.secondary_value));
                    check_field("tbl_id", 32'(want.tbl_id), 32'(m_data.tbl_id));
                    check_field("version", 32'(want.version), 32'(m_data.version));
                    check_field("sect_num", 32'(want.sect_num), 32'(m_data.sect_num));
                    check_field("last_sect_num", 32'(want.last_sect_num),
                                32'(m_data.last_sect_num));
                    check_field("flag_bits", 32'(want.flag_bits), 32'(m_data.flag_bits));
                    check_field("run_state", 32'(want.run_state), 32'(m_data.run_state));
                    check_field("sect_len", 32'(want.sect_len), 32'(m_data.sect_len));
                    check_field("crc_value", want.crc_value, m_data.crc_value);
                    check_field("data_byte", 32'(want.data_byte), 32'(m_data.data_byte));
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_data, produces, predicted);
                if (produces) expected_recs.insert(expected_recs.size(), predicted);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input sdsp_pkg::in_t item);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_noise(input int unsigned count);
        sdsp_pkg::in_t item;
        repeat (count) begin
            item.section_byte = 8'($urandom);
            item.first_byte = 1'b0;
            send_byte(item);
        end
    endtask

    task automatic send_section();
        sdsp_pkg::in_t item;
        foreach (section_bytes[i]) begin
            item.section_byte = section_bytes[i];
            item.first_byte = (i == 0);
            send_byte(item);
        end
        sections_sent++;
        bytes_sent += section_bytes.size();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_recs.size() != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    function automatic void add_byte(bit [7:0] v);
        section_bytes.insert(section_bytes.size(), v);
    endfunction

    function automatic void start_section(bit [7:0] tid, bit syn, bit [15:0] tsid,
                                          bit [4:0] ver, bit cur, bit [7:0] snum,
                                          bit [7:0] lnum, bit [15:0] onid);
        bit [2:0] rsv3;
        bit [1:0] rsv2;
        rsv3 = 3'($urandom);
        rsv2 = 2'($urandom);
        section_bytes = {};
        add_byte(tid);
        add_byte({syn, rsv3, 4'h0});
        add_byte(8'h00);
        add_byte(tsid[15:8]);
        add_byte(tsid[7:0]);
        add_byte({rsv2, ver, cur});
        add_byte(snum);
        add_byte(lnum);
        add_byte(onid[15:8]);
        add_byte(onid[7:0]);
        add_byte(8'($urandom));
    endfunction

    function automatic void start_any_section();
        start_section(8'($urandom), 1'($urandom), 16'($urandom), 5'($urandom),
                      1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    function automatic void set_length(bit [11:0] len);
        bit [7:0] hi;
        hi = section_bytes[1];
        hi[3:0] = len[11:8];
        section_bytes[1] = hi;
        section_bytes[2] = len[7:0];
    endfunction

    function automatic void close_section(bit [31:0] crc);
        set_length(12'(section_bytes.size() + 1));
        add_byte(crc[31:24]);
        add_byte(crc[23:16]);
        add_byte(crc[15:8]);
        add_byte(crc[7:0]);
    endfunction

    function automatic void put_service(bit [15:0] sid, bit [2:0] run, bit fca,
                                        bit [1:0] eit, bit [11:0] loop_len);
        bit [5:0] rsv6;
        rsv6 = 6'($urandom);
        add_byte(sid[15:8]);
        add_byte(sid[7:0]);
        add_byte({rsv6, eit});
        add_byte({run, fca, loop_len[11:8]});
        add_byte(loop_len[7:0]);
    endfunction

    function automatic void put_any_service(bit [11:0] loop_len);
        put_service(16'($urandom), 3'($urandom), 1'($urandom), 2'($urandom), loop_len);
    endfunction

    function automatic void put_descriptor(bit [7:0] tag, bit [7:0] len);
        add_byte(tag);
        add_byte(len);
        repeat (len) add_byte(8'($urandom));
    endfunction

    function automatic void put_random_service(int unsigned min_len, int unsigned max_len);
        int unsigned dlen[4];
        int unsigned count;
        int unsigned total;
        bit lone;
        count = $urandom_range(3);
        lone = ($urandom_range(3) == 0);
        total = lone ? 1 : 0;
        for (int i = 0; i < count; i++) begin
            dlen[i] = $urandom_range(max_len, min_len);
            total += 2 + dlen[i];
        end
        put_any_service(12'(total));
        for (int i = 0; i < count; i++) put_descriptor(8'($urandom), 8'(dlen[i]));
        if (lone) add_byte(8'($urandom));
    endfunction

    task automatic test_header_extremes();
        // stray bytes ahead of any section
        send_noise(2);
        start_section(8'hFF, 1'b1, 16'hFFFF, 5'h1F, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
        close_section(32'hFFFF_FFFF);
        send_section();
        start_section(8'h00, 1'b0, 16'h0000, 5'h00, 1'b0, 8'h00, 8'h00, 16'h0000);
        close_section(32'h0000_0000);
        send_section();
    endtask

    task automatic test_short_section();
        start_any_section();
        set_length(12'd0);
        send_section();
        start_any_section();
        set_length(12'(sdsp_pkg::MIN_SECTION_LEN - 1));
        send_section();
        send_noise(2);
    endtask

    task automatic test_service_loop();
        start_section(8'h42, 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'h00, 8'h01,
                      16'($urandom));
        // empty descriptor loop, then a loop with an empty descriptor, a two-byte descriptor and a lone byte
        put_service(16'hFFFF, 3'h7, 1'b1, 2'b11, 12'd0);
        put_service(16'h0000, 3'h0, 1'b0, 2'b00, 12'd7);
        put_descriptor(8'hFF, 8'd0);
        add_byte(8'h00);
        add_byte(8'd2);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'($urandom));
        put_service(16'h1234, 3'h4, 1'b0, 2'b10, 12'd5);
        put_descriptor(8'h48, 8'd3);
        close_section($urandom);
        send_section();
    endtask

    task automatic test_malformed_layouts();
        // service header runs into the CRC
        start_section(8'($urandom), 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'h00, 8'h00,
                      16'($urandom));
        put_any_service(12'd0);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        close_section($urandom);
        send_section();
        // descriptor loop past the CRC at the largest section length
        start_section(8'($urandom), 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'h00, 8'h00,
                      16'($urandom));
        put_any_service(12'hFFF);
        set_length(12'hFFF);
        send_section();
        // descriptor longer than its loop
        start_section(8'($urandom), 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'h00, 8'h00,
                      16'($urandom));
        put_any_service(12'd3);
        put_descriptor(8'($urandom), 8'd5);
        close_section($urandom);
        send_section();
    endtask

    task automatic test_restart();
        start_section(8'($urandom), 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'($urandom),
                      8'($urandom), 16'($urandom));
        put_random_service(1, 4);
        put_random_service(1, 4);
        close_section($urandom);
        while (section_bytes.size() > 14) void'(section_bytes.pop_back());
        send_section();
        start_section(8'($urandom), 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'($urandom),
                      8'($urandom), 16'($urandom));
        put_random_service(0, 4);
        close_section($urandom);
        send_section();
        send_noise(3);
    endtask

    task automatic test_random_sections(input int unsigned byte_budget);
        int unsigned start_bytes;
        int unsigned pick;
        int unsigned cut;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < byte_budget) begin
            start_any_section();
            repeat ($urandom_range(4)) put_random_service(0, ($urandom_range(7) == 0) ? 40 : 8);
            close_section($urandom);
            pick = $urandom_range(99);
            if (pick >= 90) begin
                section_bytes[$urandom_range(section_bytes.size() - 1, 1)] = 8'($urandom);
            end else if (pick >= 83) begin
                set_length(12'(section_bytes.size() - 7 + $urandom_range(8)));
            end else if (pick >= 78) begin
                set_length(12'($urandom));
            end else if (pick >= 70) begin
                cut = $urandom_range(section_bytes.size() - 1, 1);
                while (section_bytes.size() > cut) void'(section_bytes.pop_back());
            end
            send_section();
            if ($urandom_range(9) == 0) send_noise($urandom_range(3, 1));
        end
    endtask

    task automatic test_long_section();
        // descriptor loop longer than 255 bytes
        start_section(8'($urandom), 1'b1, 16'($urandom), 5'($urandom), 1'b1, 8'($urandom),
                      8'($urandom), 16'($urandom));
        put_any_service(12'd514);
        put_descriptor(8'($urandom), 8'd255);
        put_descriptor(8'($urandom), 8'd255);
        close_section($urandom);
        send_section();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_extremes();
        test_short_section();
        test_service_loop();
        test_malformed_layouts();
        test_restart();
        test_random_sections(RANDOM_BYTES / 3);
        wait_drained();

        src_idle_pct = 59;
        snk_idle_pct = 36;
        test_random_sections(RANDOM_BYTES / 3);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_sections(RANDOM_BYTES / 3);
        test_long_section();
        wait_drained();

        $display("Sent %0d sections (%0d bytes), including short, truncated and corrupted ones.",
                 sections_sent, bytes_sent);
        $display("Checked %0d records: %0d malformed, %0d CRC.",
                 records_checked, malformed_seen, crc_seen);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
